// ===== src/sbusfd_pkg.sv =====
// Shared constants and types of the serial bus frame decoder.
package sbusfd_pkg;

  localparam int unsigned FrameLen     = 25;
  localparam int unsigned CntW         = 5;
  localparam logic [7:0]  FrameHead    = 8'h0F;
  localparam logic [7:0]  FrameTail    = 8'h00;
  localparam int unsigned ChanW        = 11;
  localparam int unsigned ChanCount    = 8;
  localparam int unsigned PayloadBytes = 11;
  localparam int unsigned PayloadW     = 8 * PayloadBytes;
  localparam int unsigned StampW       = 32;
  localparam int unsigned GapW         = 16;
  localparam logic [GapW-1:0] GapResetUs = 16'd2000;
  localparam int unsigned InDataW      = 8 + StampW;
  localparam int unsigned OutDataW     = ChanW * ChanCount;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QPtrW        = $clog2(QueueDepth);
  localparam int unsigned QCntW        = $clog2(QueueDepth + 1);

  typedef logic [PayloadW-1:0] payload_t;

  typedef struct packed {
    logic     push;
    payload_t data;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/sbusfd_front.sv =====
// Front end: gap detection, byte counting, header/footer check, payload capture.
module sbusfd_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sbusfd_pkg::GapW-1:0]        cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sbusfd_pkg::InDataW-1:0]     s_axis_tdata,
  input  sbusfd_pkg::q_stat_t                q_stat_i,
  output sbusfd_pkg::q_wr_t                  q_wr_o
);

  logic [sbusfd_pkg::GapW-1:0]   thr_q;
  logic [sbusfd_pkg::StampW-1:0] last_q, last_d, now, gap;
  logic [sbusfd_pkg::CntW-1:0]   cnt_q, cnt_d, cnt_eff, cnt_inc;
  logic                          head_q, head_d;
  logic [7:0]                    data_q [sbusfd_pkg::PayloadBytes];
  logic [7:0]                    rx_byte;
  logic [3:0]                    wr_idx;
  logic                          accept, restart, store, frame_done, wr_payload;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_stat_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign rx_byte = s_axis_tdata[7:0];
  assign now     = s_axis_tdata[sbusfd_pkg::InDataW-1:8];
  assign gap     = now - last_q;
  assign restart = gap > {{(sbusfd_pkg::StampW-sbusfd_pkg::GapW){1'b0}}, thr_q};
  assign cnt_eff = restart ? '0 : cnt_q;
  assign cnt_inc = cnt_eff + 1'b1;
  assign store   = accept && (cnt_eff < sbusfd_pkg::CntW'(sbusfd_pkg::FrameLen));
  assign frame_done = store && (cnt_inc == sbusfd_pkg::CntW'(sbusfd_pkg::FrameLen)) &&
                      head_q && (rx_byte == sbusfd_pkg::FrameTail);
  assign wr_idx     = 4'(cnt_eff - 1'b1);
  assign wr_payload = store && (cnt_eff != '0) &&
                      (cnt_eff <= sbusfd_pkg::CntW'(sbusfd_pkg::PayloadBytes));

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    last_d = last_q;
    if (accept) begin
      last_d = now;
      cnt_d  = cnt_eff;
      if (store) begin
        cnt_d = frame_done ? '0 : cnt_inc;
        if (cnt_eff == '0) head_d = (rx_byte == sbusfd_pkg::FrameHead);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= sbusfd_pkg::GapResetUs;
      last_q <= '0;
      cnt_q  <= '0;
      head_q <= 1'b0;
    end else begin
      if (cfg_valid_i) thr_q <= cfg_data_i;
      last_q <= last_d;
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_payload) data_q[wr_idx] <= rx_byte;
  end

  always_comb begin
    q_wr_o.push = frame_done;
    for (int i = 0; i < sbusfd_pkg::PayloadBytes; i++) begin
      q_wr_o.data[8*i +: 8] = data_q[i];
    end
  end

endmodule

// ===== src/sbusfd_queue.sv =====
// Short queue of completed frame payloads between front and back end.
module sbusfd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbusfd_pkg::q_wr_t    q_wr_i,
  input  logic                 pop_i,
  output sbusfd_pkg::payload_t head_o,
  output sbusfd_pkg::q_stat_t  q_stat_o
);

  sbusfd_pkg::payload_t           mem_q [sbusfd_pkg::QueueDepth];
  logic [sbusfd_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [sbusfd_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign q_stat_o.full  = (cnt_q == sbusfd_pkg::QCntW'(sbusfd_pkg::QueueDepth));
  assign q_stat_o.empty = (cnt_q == '0);
  assign do_push = q_wr_i.push && !q_stat_o.full;
  assign do_pop  = pop_i && !q_stat_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= q_wr_i.data;
  end

endmodule

// ===== src/sbusfd_back.sv =====
// Back end: unpacks 11-bit channels from a payload into the output register.
module sbusfd_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sbusfd_pkg::payload_t              head_i,
  input  sbusfd_pkg::q_stat_t               q_stat_i,
  output logic                              pop_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sbusfd_pkg::OutDataW-1:0]   m_axis_tdata
);

  logic                                valid_q;
  logic [sbusfd_pkg::ChanW-1:0]        chan   [sbusfd_pkg::ChanCount];
  logic [sbusfd_pkg::ChanW-1:0]        chan_q [sbusfd_pkg::ChanCount];

  assign pop_o = !q_stat_i.empty && (!valid_q || m_axis_tready);

  // channel k takes bits 11k..11k+10 of the little-endian payload stream
  always_comb begin
    for (int k = 0; k < sbusfd_pkg::ChanCount; k++) begin
      chan[k] = head_i[sbusfd_pkg::ChanW*k +: sbusfd_pkg::ChanW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) chan_q <= chan;
  end

  assign m_axis_tvalid = valid_q;

  always_comb begin
    for (int k = 0; k < sbusfd_pkg::ChanCount; k++) begin
      m_axis_tdata[sbusfd_pkg::ChanW*k +: sbusfd_pkg::ChanW] = chan_q[k];
    end
  end

endmodule

// ===== src/sbus_frame_decoder.sv =====
// Top level of the serial bus frame decoder.
// Takes one received byte per beat with its 32-bit microsecond arrival stamp and
// emits channels 1 to 8 of every 25-byte frame that starts with 0x0F and ends
// with 0x00. A gap above gap_threshold_us (written on the cfg channel, reset
// 2000) restarts the byte count; a full frame with a bad header or footer is
// dropped and later bytes are ignored until such a gap. One byte is taken every
// cycle while the frame queue is not full; a frame result passes through a
// two-entry frame queue and an output register, so the input stalls only when
// both are full.
module sbus_frame_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sbusfd_pkg::GapW-1:0]      cfg_data_i,      // gap_threshold_us
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sbusfd_pkg::InDataW-1:0]   s_axis_tdata,    // data_byte, arrival_time_us
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [sbusfd_pkg::OutDataW-1:0]  m_axis_tdata     // channel_1 .. channel_8
);

  sbusfd_pkg::q_wr_t    q_wr;
  sbusfd_pkg::q_stat_t  q_stat;
  sbusfd_pkg::payload_t q_head;
  logic                 q_pop;

  sbusfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_stat_i      (q_stat),
    .q_wr_o        (q_wr)
  );

  sbusfd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_wr_i   (q_wr),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .q_stat_o (q_stat)
  );

  sbusfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .q_stat_i      (q_stat),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr.push |-> !q_stat.full) else $error("frame pushed into full queue");

  a_stat_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty)) else $error("queue both full and empty");

  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_stat.empty && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("output register not filled from queue");
`endif

endmodule

// ===== tb/tb_sbus_frame_decoder.sv =====
// Self-checking testbench for the serial bus frame decoder: framing, gaps, stamp wrap, backpressure.
`timescale 1ns / 100ps

module tb_sbus_frame_decoder;

  localparam int unsigned LongHold   = 300;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 50;

  typedef enum int {
    KindGood,
    KindBadHead,
    KindBadTail,
    KindFragment,
    KindNoGap
  } frame_kind_e;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [sbusfd_pkg::GapW-1:0]     cfg_data_i = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [sbusfd_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [sbusfd_pkg::OutDataW-1:0] m_axis_tdata;

  sbus_frame_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]                      rx_buf [sbusfd_pkg::FrameLen];
  int unsigned                     rx_fill = 0;
  logic [sbusfd_pkg::StampW-1:0]   rx_last_stamp = '0;
  logic [sbusfd_pkg::GapW-1:0]     gap_thr = sbusfd_pkg::GapResetUs;
  logic [sbusfd_pkg::OutDataW-1:0] pending_frames [$];

  logic [sbusfd_pkg::StampW-1:0]   stamp_us = '0;
  bit                              src_idle_en = 1'b1;
  bit                              sink_idle_en = 1'b1;
  int                              hold_reqs = 0;
  int                              holds_seen = 0;
  int unsigned                     hold_left = 0;
  int unsigned                     stall_cycles = 0;
  int unsigned                     errors = 0;
  logic [sbusfd_pkg::OutDataW-1:0] want_chans;

  task automatic report_mismatch(input string msg);
    if (errors < MaxReports) $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void predict_channels(input logic [7:0] b,
                                           input logic [sbusfd_pkg::StampW-1:0] t);
    logic [sbusfd_pkg::StampW-1:0]   gap;
    logic [sbusfd_pkg::OutDataW-1:0] chans;
    gap = t - rx_last_stamp;
    if (gap > {{(sbusfd_pkg::StampW-sbusfd_pkg::GapW){1'b0}}, gap_thr}) rx_fill = 0;
    if (rx_fill < sbusfd_pkg::FrameLen) begin
      rx_buf[rx_fill] = b;
      rx_fill++;
      if (rx_fill == sbusfd_pkg::FrameLen && rx_buf[0] == sbusfd_pkg::FrameHead &&
          rx_buf[sbusfd_pkg::FrameLen-1] == sbusfd_pkg::FrameTail) begin
        // payload bytes 1..11 form the little-endian channel bit stream
        for (int i = 0; i < sbusfd_pkg::PayloadBytes; i++) chans[8*i +: 8] = rx_buf[1+i];
        pending_frames.push_back(chans);
        rx_fill = 0;
      end
    end
    rx_last_stamp = t;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic [sbusfd_pkg::StampW-1:0] t);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_channels(b, t);
  endtask

  task automatic write_gap(input logic [sbusfd_pkg::GapW-1:0] thr);
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= thr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    gap_thr = thr;
  endtask

  function automatic logic [sbusfd_pkg::StampW-1:0] inner_delta();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return sbusfd_pkg::StampW'(gap_thr);
      default: return sbusfd_pkg::StampW'($urandom_range(0, gap_thr));
    endcase
  endfunction

  function automatic logic [sbusfd_pkg::StampW-1:0] restart_delta();
    if ($urandom_range(0, 1) == 0) return sbusfd_pkg::StampW'(gap_thr) + 1;
    return sbusfd_pkg::StampW'(gap_thr) + 1 +
           sbusfd_pkg::StampW'($urandom_range(0, 32'h7FFF_FFFF));
  endfunction

  task automatic send_frame(input frame_kind_e kind);
    logic [7:0]  fb [sbusfd_pkg::FrameLen];
    int unsigned len;
    int unsigned fill_mode;
    fill_mode = $urandom_range(0, 7);
    for (int i = 0; i < sbusfd_pkg::FrameLen; i++) begin
      if (fill_mode == 0) fb[i] = 8'h00;
      else if (fill_mode == 1) fb[i] = 8'hFF;
      else fb[i] = 8'($urandom);
    end
    fb[0] = sbusfd_pkg::FrameHead;
    fb[sbusfd_pkg::FrameLen-1] = sbusfd_pkg::FrameTail;
    len = sbusfd_pkg::FrameLen;
    case (kind)
      KindBadHead: do fb[0] = 8'($urandom); while (fb[0] == sbusfd_pkg::FrameHead);
      KindBadTail: do fb[sbusfd_pkg::FrameLen-1] = 8'($urandom);
        while (fb[sbusfd_pkg::FrameLen-1] == sbusfd_pkg::FrameTail);
      KindFragment: len = $urandom_range(1, sbusfd_pkg::FrameLen - 1);
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      stamp_us += (i == 0 && kind != KindNoGap) ? restart_delta() : inner_delta();
      send_byte(fb[i], stamp_us);
    end
    // bytes after a dropped frame are ignored until the next gap
    if ((kind == KindBadHead || kind == KindBadTail) && $urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 3)) begin
        stamp_us += inner_delta();
        send_byte(8'($urandom), stamp_us);
      end
    end
  endtask

  task automatic send_mixed_frames(input int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) send_frame(KindGood);
      else if (pick == 6) send_frame(KindBadHead);
      else if (pick == 7) send_frame(KindBadTail);
      else if (pick == 8) send_frame(KindFragment);
      else send_frame(KindNoGap);
    end
  endtask

  // first byte after reset sees a huge gap from time 0; stamps wrap mid-frame
  task automatic test_wrap_frame();
    stamp_us = 32'hFFFF_FFF0;
    for (int i = 0; i < sbusfd_pkg::FrameLen; i++) begin
      send_byte((i == 0) ? sbusfd_pkg::FrameHead :
                (i == sbusfd_pkg::FrameLen - 1) ? sbusfd_pkg::FrameTail : 8'hFF, stamp_us);
      stamp_us += 1;
    end
  endtask

  task automatic test_bad_header();
    stamp_us += 32'd5000;
    for (int i = 0; i < sbusfd_pkg::FrameLen; i++) begin
      send_byte((i == 0) ? 8'hF0 :
                (i == sbusfd_pkg::FrameLen - 1) ? sbusfd_pkg::FrameTail : 8'h00, stamp_us);
      stamp_us += 32'd2000;
    end
    send_byte(sbusfd_pkg::FrameHead, stamp_us);
    stamp_us += 32'd2001;
    send_byte(sbusfd_pkg::FrameHead, stamp_us);
  endtask

  task automatic test_gap_setting(input logic [sbusfd_pkg::GapW-1:0] thr,
                                  input int unsigned count);
    write_gap(thr);
    send_mixed_frames(count);
  endtask

  task automatic test_backpressure();
    hold_reqs <= hold_reqs + 1;
    src_idle_en = 1'b0;
    send_frame(KindGood);
    repeat (4) send_frame(KindNoGap);
    src_idle_en = 1'b1;
  endtask

  task automatic test_full_rate();
    write_gap(sbusfd_pkg::GapResetUs);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_mixed_frames(8);
  endtask

  always @(posedge clk_i) begin
    if (hold_reqs != holds_seen) begin
      holds_seen = hold_reqs;
      hold_left  = LongHold;
    end else if (hold_left == 0 && sink_idle_en && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(1, 5);
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("frame beat with none pending: %h", m_axis_tdata));
      end else begin
        want_chans = pending_frames.pop_front();
        for (int k = 0; k < sbusfd_pkg::ChanCount; k++) begin
          if (m_axis_tdata[sbusfd_pkg::ChanW*k +: sbusfd_pkg::ChanW] !==
              want_chans[sbusfd_pkg::ChanW*k +: sbusfd_pkg::ChanW])
            report_mismatch($sformatf("channel_%0d got %h want %h", k + 1,
                                      m_axis_tdata[sbusfd_pkg::ChanW*k +: sbusfd_pkg::ChanW],
                                      want_chans[sbusfd_pkg::ChanW*k +: sbusfd_pkg::ChanW]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_wrap_frame();
    test_bad_header();
    send_mixed_frames(6);
    test_gap_setting(16'd0, 11);
    test_gap_setting(16'hFFFF, 11);
    test_gap_setting(16'd1, 11);
    test_gap_setting(16'($urandom), 11);
    test_backpressure();
    test_gap_setting(sbusfd_pkg::GapResetUs, 6);
    test_full_rate();
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_frames.size() != 0) report_mismatch("frames still pending at end");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
